// File: rtl/tut_pkg.sv
// tut_pkg: shared types and constants of the timer-driven uart transceiver
// depends on nothing; imported by tut_tx, tut_rx, timer_uart_transceiver and tb
package tut_pkg;

    // frame layout: start bit, eight data bits, two stop bits
    localparam int unsigned FRAME_BITS  = 11;
    localparam int unsigned DATA_BITS   = 8;
    localparam int unsigned BITCNT_W    = 4;

    localparam logic [BITCNT_W-1:0] TX_FRAME_LEN = 4'd11;
    localparam logic [BITCNT_W-1:0] RX_DATA_LEN  = 4'd8;
    localparam logic [1:0]          STOP_PATTERN = 2'b11;
    localparam logic                START_LEVEL  = 1'b0;
    localparam logic                IDLE_LEVEL   = 1'b1;

    // ticks per bit after reset
    localparam logic [15:0] PERIOD_RESET = 16'd104;

    // transmitter line status for one tick
    typedef struct packed {
        logic txd_level;
        logic tx_busy;
    } tx_status_t;

    // receiver result for one tick
    typedef struct packed {
        logic                 rx_valid;
        logic [DATA_BITS-1:0] rx_byte;
    } rx_result_t;

endpackage

// File: rtl/timer_uart_transceiver.sv
// timer_uart_transceiver: top level, tick input register, result register, period register
// depends on tut_pkg, tut_tx and tut_rx
//
// Usage: every transfer on the s_ channel is one timer tick. It carries the
// sampled receive line, a send request and the byte to send. Every tick gives
// exactly one transfer on the m_ channel: the transmit line level and busy flag
// after the tick, and a received byte with rx_valid on the tick its eighth data
// bit is sampled. Frames are 8N2: start bit, eight data bits LSB first, two
// stop bits, each bit_period ticks long. cfg_wr_en/cfg_wr_data write bit_period
// directly; write it only while no tick is in flight.
// Path: a tick passes the input register, then the result register, before its
// result is shown on m_. Throughput: one tick per cycle while m_ready stays high,
// set by the combinational next-state logic between the two registers.
// Reset: aresetn low clears both stages, the line goes idle, the receiver hunts
// for a start edge, and bit_period returns to 104.
// Stall: while m_ready is low the result holds; one more tick fills the input
// register, after which s_ready drops until the result is taken.
module timer_uart_transceiver #(
    parameter int unsigned TICK_COUNTER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tick input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_rxd_level,
    input  logic        s_send_request,
    input  logic [7:0]  s_tx_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_txd_level,
    output logic        m_tx_busy,
    output logic        m_rx_valid,
    output logic [7:0]  m_rx_byte,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import tut_pkg::*;

    localparam int unsigned TCB = TICK_COUNTER_BITS;

    logic [15:0]     bit_period_reg;
    logic [TCB+15:0] period_ext;
    logic [TCB-1:0]  period_cut;
    logic [TCB-1:0]  period;

    logic            in_valid_reg;
    logic            in_rxd_reg;
    logic            in_req_reg;
    logic [7:0]      in_byte_reg;
    logic            out_free;
    logic            step;

    tx_status_t      tx_status;
    rx_result_t      rx_result;

    // period register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg <= PERIOD_RESET;
        end else if (cfg_wr_en) begin
            bit_period_reg <= cfg_wr_data;
        end
    end

    // period cut to counter width, zero acts as one
    assign period_ext = {{TCB{1'b0}}, bit_period_reg};
    assign period_cut = period_ext[TCB-1:0];
    assign period     = (period_cut == '0) ? {{(TCB-1){1'b0}}, 1'b1} : period_cut;

    // handshake between the two stages
    assign out_free = !m_valid || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_rxd_reg  <= s_rxd_level;
            in_req_reg  <= s_send_request;
            in_byte_reg <= s_tx_byte;
        end
    end

    tut_tx #(
        .TICK_COUNTER_BITS(TCB)
    ) u_tx (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .send_request(in_req_reg),
        .tx_byte     (in_byte_reg),
        .period      (period),
        .status_next (tx_status)
    );

    tut_rx #(
        .TICK_COUNTER_BITS(TCB)
    ) u_rx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .rxd_level  (in_rxd_reg),
        .period     (period),
        .result_next(rx_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_free) begin
            m_valid <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_txd_level <= tx_status.txd_level;
            m_tx_busy   <= tx_status.tx_busy;
            m_rx_valid  <= rx_result.rx_valid;
            m_rx_byte   <= rx_result.rx_byte;
        end
    end

    // checks
    a_idle_line_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_tx_busy) |-> m_txd_level)
        else $error("transmit line low while transmitter idle");

    a_rx_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_rx_valid) |-> (m_rx_byte == '0))
        else $error("receive byte nonzero without rx_valid");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !in_valid_reg))
        else $error("pipeline not empty after reset");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid && !m_ready))
        else $error("input stalled with free pipeline space");

endmodule

// File: rtl/tut_tx.sv
// tut_tx: 8N2 transmitter, one tick per step, frame shift register and bit timer
// depends on tut_pkg
module tut_tx #(
    parameter int unsigned TICK_COUNTER_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic                         send_request,
    input  logic [7:0]                   tx_byte,
    input  logic [TICK_COUNTER_BITS-1:0] period,
    output tut_pkg::tx_status_t          status_next
);
    import tut_pkg::*;

    logic [FRAME_BITS-1:0]        shift_reg, shift_next;
    logic [BITCNT_W-1:0]          bits_left_reg, bits_left_next;
    logic [TICK_COUNTER_BITS-1:0] count_reg, count_next;
    logic [TICK_COUNTER_BITS-1:0] count_inc;
    logic                         bit_end;
    logic                         busy;

    assign busy      = (bits_left_reg != '0);
    assign count_inc = count_reg + {{(TICK_COUNTER_BITS-1){1'b0}}, 1'b1};
    assign bit_end   = (count_inc >= period) || (count_inc == '0);

    // bit timing and frame load
    always_comb begin
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        count_next     = count_reg;
        if (busy) begin
            count_next = count_inc;
            if (bit_end) begin
                count_next     = '0;
                shift_next     = {IDLE_LEVEL, shift_reg[FRAME_BITS-1:1]};
                bits_left_next = bits_left_reg - {{(BITCNT_W-1){1'b0}}, 1'b1};
            end
        end else if (send_request) begin
            shift_next     = {STOP_PATTERN, tx_byte, START_LEVEL};
            bits_left_next = TX_FRAME_LEN;
            count_next     = '0;
        end
    end

    // line status after this tick
    always_comb begin
        status_next.tx_busy   = (bits_left_next != '0);
        status_next.txd_level = status_next.tx_busy ? shift_next[0] : IDLE_LEVEL;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg     <= '1;
            bits_left_reg <= '0;
            count_reg     <= '0;
        end else if (step) begin
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            count_reg     <= count_next;
        end
    end

endmodule

// File: rtl/tut_rx.sv
// tut_rx: receiver with start edge hunt, mid-bit sampling and byte assembly
// depends on tut_pkg
module tut_rx #(
    parameter int unsigned TICK_COUNTER_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic                         rxd_level,
    input  logic [TICK_COUNTER_BITS-1:0] period,
    output tut_pkg::rx_result_t          result_next
);
    import tut_pkg::*;

    localparam int unsigned CNT_W = TICK_COUNTER_BITS + 1;

    logic                 hunting_reg, hunting_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [BITCNT_W-1:0]  bits_left_reg, bits_left_next;
    logic [BITCNT_W-1:0]  bits_dec;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     count_inc;
    logic [CNT_W-1:0]     target;
    logic                 prev_reg;

    // first sample is one and a half periods after the edge
    assign target = (bits_left_reg == RX_DATA_LEN)
                    ? ({1'b0, period} + {2'b00, period[TICK_COUNTER_BITS-1:1]})
                    : {1'b0, period};
    assign count_inc = count_reg + {{(CNT_W-1){1'b0}}, 1'b1};
    assign bits_dec  = bits_left_reg - {{(BITCNT_W-1){1'b0}}, 1'b1};

    // hunt, time and sample
    always_comb begin
        hunting_next         = hunting_reg;
        shift_next           = shift_reg;
        bits_left_next       = bits_left_reg;
        count_next           = count_reg;
        result_next.rx_valid = 1'b0;
        result_next.rx_byte  = '0;
        if (hunting_reg) begin
            if (prev_reg && !rxd_level) begin
                hunting_next   = 1'b0;
                count_next     = '0;
                bits_left_next = RX_DATA_LEN;
            end
        end else begin
            count_next = count_inc;
            if (count_inc >= target) begin
                count_next     = '0;
                shift_next     = {rxd_level, shift_reg[DATA_BITS-1:1]};
                bits_left_next = bits_dec;
                if (bits_dec == '0 || bits_dec > RX_DATA_LEN) begin
                    result_next.rx_valid = 1'b1;
                    result_next.rx_byte  = shift_next;
                    bits_left_next       = RX_DATA_LEN;
                    hunting_next         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hunting_reg   <= 1'b1;
            shift_reg     <= '0;
            bits_left_reg <= RX_DATA_LEN;
            count_reg     <= '0;
            prev_reg      <= IDLE_LEVEL;
        end else if (step) begin
            hunting_reg   <= hunting_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            count_reg     <= count_next;
            prev_reg      <= rxd_level;
        end
    end

endmodule

// File: dv/tb.sv
// tb: self-checking testbench for timer_uart_transceiver (8n2 uart driven by timer ticks)
// depends on tut_pkg and the rtl top level; a tick-accurate line model predicts every result
module tb;

    import tut_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_SHOWN   = 10;

    // expected line state after one tick
    typedef struct packed {
        tx_status_t tx;
        rx_result_t rx;
    } line_result_t;

    // tick-accurate model of both uart halves plus the queue of expected results
    class uart_line_scoreboard;
        logic [15:0]          period;
        logic [10:0]          tx_frame;
        logic [BITCNT_W-1:0]  tx_left;
        logic [15:0]          tx_ticks;
        logic                 rx_hunting;
        logic [DATA_BITS-1:0] rx_data;
        logic [BITCNT_W-1:0]  rx_left;
        logic [16:0]          rx_ticks;
        logic                 rxd_prev;
        line_result_t         line_states[$];
        int unsigned          errors;
        int unsigned          ticks;
        int unsigned          frames_sent;
        int unsigned          bytes_seen;

        function new();
            period      = PERIOD_RESET;
            tx_frame    = '1;
            tx_left     = '0;
            tx_ticks    = '0;
            rx_hunting  = 1'b1;
            rx_data     = '0;
            rx_left     = RX_DATA_LEN;
            rx_ticks    = '0;
            rxd_prev    = IDLE_LEVEL;
            errors      = 0;
            ticks       = 0;
            frames_sent = 0;
            bytes_seen  = 0;
        endfunction

        function int pending();
            return line_states.size();
        endfunction

        // advance both halves by one accepted tick and queue the resulting line state
        function void note_tick(logic rxd, logic req, logic [7:0] data);
            logic [15:0]  per;
            logic [16:0]  target;
            line_result_t r;
            per = (period == 16'd0) ? 16'd1 : period;
            r = '0;
            ticks++;

            // transmitter: count out the bit, then shift in idle level
            if (tx_left != '0) begin
                tx_ticks = tx_ticks + 16'd1;
                if (tx_ticks >= per || tx_ticks == 16'd0) begin
                    tx_ticks = '0;
                    tx_frame = {IDLE_LEVEL, tx_frame[10:1]};
                    tx_left  = tx_left - 1'b1;
                end
            end else if (req) begin
                tx_frame = {STOP_PATTERN, data, START_LEVEL};
                tx_left  = TX_FRAME_LEN;
                tx_ticks = '0;
                frames_sent++;
            end

            // receiver: hunt for falling edge, then sample mid-bit
            if (rx_hunting) begin
                if (rxd_prev && !rxd) begin
                    rx_hunting = 1'b0;
                    rx_ticks   = '0;
                    rx_left    = RX_DATA_LEN;
                end
            end else begin
                target = (rx_left == RX_DATA_LEN) ? ({1'b0, per} + (per >> 1)) : {1'b0, per};
                rx_ticks = rx_ticks + 17'd1;
                if (rx_ticks >= target) begin
                    rx_ticks = '0;
                    rx_data  = {rxd, rx_data[7:1]};
                    rx_left  = rx_left - 1'b1;
                    if (rx_left == '0 || rx_left > RX_DATA_LEN) begin
                        r.rx.rx_valid = 1'b1;
                        r.rx.rx_byte  = rx_data;
                        rx_left       = RX_DATA_LEN;
                        rx_hunting    = 1'b1;
                        bytes_seen++;
                    end
                end
            end
            rxd_prev = rxd;

            r.tx.tx_busy   = (tx_left != '0);
            r.tx.txd_level = (tx_left != '0) ? tx_frame[0] : IDLE_LEVEL;
            line_states.push_back(r);
        endfunction

        // compare one result transfer against the oldest expectation
        function void check_result(logic txd, logic busy, logic rxv, logic [7:0] rxb);
            line_result_t e;
            if (line_states.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected result: txd=%b busy=%b rx_valid=%b rx_byte=%02h",
                             txd, busy, rxv, rxb);
                return;
            end
            e = line_states.pop_front();
            if (txd !== e.tx.txd_level || busy !== e.tx.tx_busy ||
                rxv !== e.rx.rx_valid || rxb !== e.rx.rx_byte) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display({"mismatch: txd %b/%b busy %b/%b rx_valid %b/%b ",
                              "rx_byte %02h/%02h (exp/got)"},
                             e.tx.txd_level, txd, e.tx.tx_busy, busy,
                             e.rx.rx_valid, rxv, e.rx.rx_byte, rxb);
            end
        endfunction
    endclass

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic        s_rxd_level    = IDLE_LEVEL;
    logic        s_send_request = 1'b0;
    logic [7:0]  s_tx_byte      = 8'h00;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic        m_txd_level;
    logic        m_tx_busy;
    logic        m_rx_valid;
    logic [7:0]  m_rx_byte;
    logic        cfg_wr_en      = 1'b0;
    logic [15:0] cfg_wr_data    = PERIOD_RESET;

    uart_line_scoreboard sb = new();
    bit          gaps_on     = 1'b1;
    int unsigned cur_period  = PERIOD_RESET;
    int unsigned settings    = 0;
    int unsigned cycles      = 0;

    timer_uart_transceiver dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rxd_level    (s_rxd_level),
        .s_send_request (s_send_request),
        .s_tx_byte      (s_tx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_txd_level    (m_txd_level),
        .m_tx_busy      (m_tx_busy),
        .m_rx_valid     (m_rx_valid),
        .m_rx_byte      (m_rx_byte),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= !gaps_on || ($urandom_range(0, 99) >= 20);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_txd_level, m_tx_busy, m_rx_valid, m_rx_byte);
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // byte to send, weighted toward the extremes
    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // one tick transfer, with an optional gap before it
    task automatic put_tick(input logic rxd, input logic req, input logic [7:0] data);
        if (gaps_on && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_rxd_level    <= rxd;
        s_send_request <= req;
        s_tx_byte      <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_tick(rxd, req, data);
    endtask

    // receive line level with random transmit requests alongside
    task automatic line_tick(input logic rxd);
        put_tick(rxd, $urandom_range(0, 3) == 0, pick_data());
    endtask

    // period register write once nothing is in flight
    task automatic set_period(input logic [15:0] p);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        sb.period  = p;
        cur_period = p;
        settings++;
    endtask

    // random receive line levels
    task automatic line_noise(input int unsigned n);
        repeat (n) line_tick($urandom_range(0, 1));
    endtask

    // one 8n1 frame on the receive line; a broken frame has short, random bit lengths
    task automatic rx_frame(input logic [7:0] data, input bit broken);
        logic [9:0] bits;
        int unsigned len;
        bits = {IDLE_LEVEL, data, START_LEVEL};
        for (int i = 0; i < 10; i++) begin
            len = broken ? $urandom_range(1, cur_period) : cur_period;
            repeat (len) line_tick(bits[i]);
        end
        repeat ($urandom_range(0, 2 * cur_period)) line_tick(IDLE_LEVEL);
    endtask

    // mix of clean frames, broken frames and line noise
    task automatic run_traffic(input int unsigned n_ticks);
        int unsigned stop_at;
        stop_at = sb.ticks + n_ticks;
        while (sb.ticks < stop_at) begin
            case ($urandom_range(0, 9))
                0:       line_noise($urandom_range(1, 3 * cur_period));
                1:       rx_frame(pick_data(), 1'b1);
                default: rx_frame(pick_data(), 1'b0);
            endcase
        end
    endtask

    // stimulus
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset period: start a frame, requests while busy are dropped, a stray start edge
        put_tick(IDLE_LEVEL, 1'b1, 8'hA5);
        repeat (4) put_tick(IDLE_LEVEL, 1'b1, 8'h00);
        put_tick(IDLE_LEVEL, 1'b1, 8'hFF);
        put_tick(1'b0, 1'b0, 8'h00);
        put_tick(IDLE_LEVEL, 1'b0, 8'h00);
        repeat (4) put_tick(IDLE_LEVEL, 1'b1, 8'h5A);

        // shortest period, frame and reception already in progress
        set_period(16'd4);
        repeat (30) put_tick(IDLE_LEVEL, 1'b1, 8'h00);
        rx_frame(8'h00, 1'b0);
        rx_frame(8'hFF, 1'b0);
        run_traffic(250);

        // long stretch without idling on either side
        gaps_on = 1'b0;
        set_period(16'($urandom_range(5, 9)));
        run_traffic(250);
        gaps_on = 1'b1;

        // longest period: the ticks that follow cover only part of one bit
        set_period(16'hFFFF);
        repeat (3) put_tick(IDLE_LEVEL, 1'b1, pick_data());
        line_noise(60);

        // period drops while both halves are mid-frame
        set_period(16'd4);
        run_traffic(200);

        set_period(16'($urandom_range(4, 12)));
        run_traffic(250);

        // drain
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("ran %0d ticks over %0d period settings", sb.ticks, settings);
        $display("frames sent: %0d, bytes received: %0d, mismatches: %0d",
                 sb.frames_sent, sb.bytes_seen, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
